[hdl/rer_pkg.sv]
// Shared types, codes and ring helpers for the recent-entry ring.
`default_nettype none
package rer_pkg;

  localparam int MAX_SLOTS = 32;
  localparam int SLOT_W    = 5;
  localparam int LSIZE_W   = 6;
  localparam int DIGIT_W   = 40;
  localparam int STAMP_W   = 64;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;

  localparam logic [LSIZE_W-1:0] LSIZE_RESET = LSIZE_W'(20);
  localparam logic [LSIZE_W-1:0] LSIZE_MIN   = LSIZE_W'(2);
  localparam logic [LSIZE_W-1:0] LSIZE_MAX   = LSIZE_W'(MAX_SLOTS);

  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FREE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DEL1,
    ST_DEL2,
    ST_DEL3,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic cfg_wr;
    logic eval;
    logic del1;
    logic del2;
    logic del3;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic del_go;
  } dp_sts_t;

  // Forward link of a freshly formed ring.
  function automatic logic [SLOT_W-1:0] ring_fwd(input logic [SLOT_W-1:0] i,
                                                  input logic [LSIZE_W-1:0] ls);
    logic [LSIZE_W-1:0] nx;
    nx = {1'b0, i} + LSIZE_W'(1);
    if ({1'b0, i} >= ls || nx == ls) return '0;
    return nx[SLOT_W-1:0];
  endfunction

  // Backward link of a freshly formed ring.
  function automatic logic [SLOT_W-1:0] ring_back(input logic [SLOT_W-1:0] i,
                                                   input logic [LSIZE_W-1:0] ls);
    logic [LSIZE_W-1:0] pv;
    pv = ls - LSIZE_W'(1);
    if ({1'b0, i} >= ls) return '0;
    if (i == '0) return pv[SLOT_W-1:0];
    return i - SLOT_W'(1);
  endfunction

  // Clamp a written size into the legal range.
  function automatic logic [LSIZE_W-1:0] clamp_size(input logic [LSIZE_W-1:0] v);
    if (v < LSIZE_MIN) return LSIZE_MIN;
    if (v > LSIZE_MAX) return LSIZE_MAX;
    return v;
  endfunction

endpackage
`default_nettype wire

[hdl/rer_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rer_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/rer_ctrl.sv]
// Sequencer for add, delete and read items and configuration writes.
`default_nettype none
module rer_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  rer_pkg::dp_sts_t sts,
  output rer_pkg::cmd_t   cmd
);
  import rer_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !cfg_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = sts.del_go ? ST_DEL1 : ST_RESP;
      end
      ST_DEL1: state_next = ST_DEL2;
      ST_DEL2: state_next = ST_DEL3;
      ST_DEL3: state_next = ST_RESP;
      ST_RESP: begin
        if (sts.out_free) state_next = in_valid ? ST_EVAL : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
      end
      ST_EVAL: cmd.eval = 1'b1;
      ST_DEL1: cmd.del1 = 1'b1;
      ST_DEL2: cmd.del2 = 1'b1;
      ST_DEL3: cmd.del3 = 1'b1;
      ST_RESP: begin
        in_ready = sts.out_free;
        cmd.load = sts.out_free;
      end
      default: ;
    endcase
    cmd.accept = in_valid && in_ready;
    cmd.cfg_wr = cfg_valid && cfg_ready;
  end

endmodule
`default_nettype wire

[hdl/rer_dp.sv]
// Datapath: link and record memories, pointers, used marks, result register.
`default_nettype none
module rer_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  rer_pkg::cmd_t                 cmd,
  output rer_pkg::dp_sts_t              sts,
  input  logic [rer_pkg::LSIZE_W-1:0]   list_size,
  input  logic [rer_pkg::KIND_W-1:0]    kind,
  input  logic [rer_pkg::DIGIT_W-1:0]   phone_digits,
  input  logic [rer_pkg::STAMP_W-1:0]   time_stamp,
  input  logic [rer_pkg::SLOT_W-1:0]    slot,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rer_pkg::STAT_W-1:0]    status,
  output logic [rer_pkg::DIGIT_W-1:0]   rec_digits,
  output logic [rer_pkg::STAMP_W-1:0]   rec_stamp,
  output logic                          rec_used,
  output logic [rer_pkg::SLOT_W-1:0]    older_slot,
  output logic [rer_pkg::SLOT_W-1:0]    newer_slot,
  output logic [rer_pkg::SLOT_W-1:0]    head_slot,
  output logic [rer_pkg::SLOT_W-1:0]    tail_slot
);
  import rer_pkg::*;

  // control state
  logic [LSIZE_W-1:0]   lsize;
  logic [SLOT_W-1:0]    head, head_next;
  logic [SLOT_W-1:0]    tail, tail_next;
  logic [MAX_SLOTS-1:0] used;
  logic [MAX_SLOTS-1:0] fwd_vld;
  logic [MAX_SLOTS-1:0] back_vld;

  // captured item and scratch
  logic [KIND_W-1:0]  kind_q;
  logic [DIGIT_W-1:0] digits_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [SLOT_W-1:0]  s_q;
  logic [STAT_W-1:0]  stat_q, stat_next;
  logic [SLOT_W-1:0]  nxt, prv, fh, after_q, after_next;

  // read-side registers beside the memories
  logic [SLOT_W-1:0] fa_addr, fb_addr;
  logic [SLOT_W-1:0] fa_addr_q, fb_addr_q, bk_addr_q;
  logic              fa_vld_q, fb_vld_q, bk_vld_q;
  logic              fa_re;
  logic [SLOT_W-1:0] fa_rdata, fb_rdata, bk_rdata;
  logic [SLOT_W-1:0] fa_val, fb_val, bk_val;
  logic [DIGIT_W-1:0] dig_rdata;
  logic [STAMP_W-1:0] stp_rdata;

  // write ports
  logic              fwd_we, back_we, rec_we;
  logic [SLOT_W-1:0] fwd_waddr, fwd_wdata, back_waddr, back_wdata;

  logic in_range, is_read, is_del;
  logic full, hit_head;

  assign is_read  = (kind_q == KIND_READ);
  assign is_del   = (kind_q == KIND_DEL);
  assign in_range = ({1'b0, s_q} < lsize);

  assign sts.del_go   = is_del && in_range && used[s_q];
  assign sts.out_free = !out_valid || out_ready;

  // read addresses: add looks at head and tail, others at the slot and head
  assign fa_addr = cmd.accept ? ((kind == KIND_ADD) ? head : slot) : tail;
  assign fb_addr = (kind == KIND_ADD) ? tail : head;
  assign fa_re   = cmd.accept || (cmd.eval && sts.del_go);

  // an unwritten link entry reads as the freshly formed ring
  assign fa_val = fa_vld_q ? fa_rdata : ring_fwd(fa_addr_q, lsize);
  assign fb_val = fb_vld_q ? fb_rdata : ring_fwd(fb_addr_q, lsize);
  assign bk_val = bk_vld_q ? bk_rdata : ring_back(bk_addr_q, lsize);

  // delete: pointer moves use only values read before any link write
  assign full       = (fh == tail);
  assign hit_head   = full && (s_q == head);
  assign after_next = (head_next == prv) ? nxt : (hit_head ? fa_val : fh);

  always_comb begin
    head_next = head;
    tail_next = tail;
    if (cmd.eval && kind_q == KIND_ADD) begin
      head_next = fa_val;
      if (fa_val == tail) tail_next = fb_val;
    end else if (cmd.del1) begin
      if (hit_head) head_next = fh;
      if (hit_head || s_q == tail) tail_next = fa_val;
    end
  end

  always_comb begin
    priority if ((is_del || is_read) && !in_range) stat_next = STAT_RANGE;
    else if (is_del && !used[s_q])                 stat_next = STAT_FREE;
    else                                           stat_next = STAT_DONE;
  end

  always_comb begin
    fwd_we     = cmd.del1 || cmd.del2 || cmd.del3;
    back_we    = fwd_we;
    fwd_waddr  = head;
    fwd_wdata  = s_q;
    back_waddr = (s_q == head) ? s_q : after_q;
    back_wdata = s_q;
    if (cmd.del1) begin
      fwd_waddr  = prv;
      fwd_wdata  = nxt;
      back_waddr = nxt;
      back_wdata = prv;
    end else if (cmd.del2) begin
      fwd_waddr  = s_q;
      fwd_wdata  = after_q;
      back_waddr = s_q;
      back_wdata = head;
    end
  end

  assign rec_we = cmd.eval && (kind_q == KIND_ADD);

  rer_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_fwd_a (
    .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
    .re(fa_re), .raddr(fa_addr), .rdata(fa_rdata)
  );

  rer_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_fwd_b (
    .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
    .re(cmd.accept), .raddr(fb_addr), .rdata(fb_rdata)
  );

  rer_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_back (
    .clk(clk), .we(back_we), .waddr(back_waddr), .wdata(back_wdata),
    .re(cmd.accept), .raddr(slot), .rdata(bk_rdata)
  );

  rer_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_SLOTS)) u_digits (
    .clk(clk), .we(rec_we), .waddr(head), .wdata(digits_q),
    .re(cmd.accept), .raddr(slot), .rdata(dig_rdata)
  );

  rer_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_SLOTS)) u_stamps (
    .clk(clk), .we(rec_we), .waddr(head), .wdata(stamp_q),
    .re(cmd.accept), .raddr(slot), .rdata(stp_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      lsize    <= LSIZE_RESET;
      head     <= '0;
      tail     <= '0;
      used     <= '0;
      fwd_vld  <= '0;
      back_vld <= '0;
    end else if (cmd.cfg_wr) begin
      lsize    <= clamp_size(list_size);
      head     <= '0;
      tail     <= '0;
      used     <= '0;
      fwd_vld  <= '0;
      back_vld <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      if (rec_we)   used[head] <= 1'b1;
      if (cmd.del1) used[s_q]  <= 1'b0;
      if (fwd_we)   fwd_vld[fwd_waddr]   <= 1'b1;
      if (back_we)  back_vld[back_waddr] <= 1'b1;
    end
  end

  // item capture and scratch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q    <= kind;
      digits_q  <= phone_digits;
      stamp_q   <= time_stamp;
      s_q       <= slot;
      fb_addr_q <= fb_addr;
      fb_vld_q  <= fwd_vld[fb_addr];
      bk_addr_q <= slot;
      bk_vld_q  <= back_vld[slot];
    end
    if (fa_re) begin
      fa_addr_q <= fa_addr;
      fa_vld_q  <= fwd_vld[fa_addr];
    end
    if (cmd.eval) begin
      stat_q <= stat_next;
      nxt    <= fa_val;
      fh     <= fb_val;
      prv    <= bk_val;
    end
    if (cmd.del1) begin
      after_q <= after_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status    <= stat_q;
      head_slot <= head;
      tail_slot <= tail;
      if (is_read && in_range) begin
        rec_digits <= dig_rdata;
        rec_stamp  <= stp_rdata;
        rec_used   <= used[s_q];
        older_slot <= bk_val;
        newer_slot <= fa_val;
      end else begin
        rec_digits <= '0;
        rec_stamp  <= '0;
        rec_used   <= 1'b0;
        older_slot <= '0;
        newer_slot <= '0;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/recent_entry_ring_with_delete.sv]
// Top level of the recent-entry ring: call history on a circular doubly linked list.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   in      | in        | in_valid / in_ready   | kind, phone_digits, time_stamp, slot
//   out     | out       | out_valid / out_ready | status, rec_*, older/newer, head/tail
//   cfg     | in        | cfg_valid / cfg_ready | list_size
//
// Add, read and a delete of a free or out-of-range slot go from evaluate to
// respond; a delete of a used slot adds three relink steps, one link write
// each, as each link memory has a single write port.
// Reset and a cfg write re-form an empty ring: per-entry valid
// bits make unwritten link entries read as the formed ring; no clearing pass.
// A result waits in the output register; the next item is taken in the same
// cycle the finished result moves into it. cfg is taken only while idle.
`default_nettype none
module recent_entry_ring_with_delete (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rer_pkg::KIND_W-1:0]   kind,
  input  logic [rer_pkg::DIGIT_W-1:0]  phone_digits,
  input  logic [rer_pkg::STAMP_W-1:0]  time_stamp,
  input  logic [rer_pkg::SLOT_W-1:0]   slot,
  // result items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rer_pkg::STAT_W-1:0]   status,
  output logic [rer_pkg::DIGIT_W-1:0]  rec_digits,
  output logic [rer_pkg::STAMP_W-1:0]  rec_stamp,
  output logic                         rec_used,
  output logic [rer_pkg::SLOT_W-1:0]   older_slot,
  output logic [rer_pkg::SLOT_W-1:0]   newer_slot,
  output logic [rer_pkg::SLOT_W-1:0]   head_slot,
  output logic [rer_pkg::SLOT_W-1:0]   tail_slot,
  // ring size register
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rer_pkg::LSIZE_W-1:0]  list_size
);
  import rer_pkg::*;

  cmd_t    cmd;   // sequencer commands to the datapath
  dp_sts_t sts;   // datapath status back to the sequencer

  // Sequencer: idle, evaluate, three relink steps, respond.
  rer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: link/record memories, head and tail, used marks, result register.
  rer_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .list_size    (list_size),
    .kind         (kind),
    .phone_digits (phone_digits),
    .time_stamp   (time_stamp),
    .slot         (slot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .rec_digits   (rec_digits),
    .rec_stamp    (rec_stamp),
    .rec_used     (rec_used),
    .older_slot   (older_slot),
    .newer_slot   (newer_slot),
    .head_slot    (head_slot),
    .tail_slot    (tail_slot)
  );

`ifndef SYNTH
  // every accepted item is evaluated in the very next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.eval)
    else $error("accepted item not evaluated");

  // relink runs as an unbroken three-step sequence
  a_relink_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.del1 |=> cmd.del2 ##1 cmd.del3)
    else $error("relink sequence broken");

  // an item and a size write never land together
  a_cfg_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && cmd.cfg_wr))
    else $error("item and cfg write in same cycle");

  // only a successful read carries record fields
  a_rec_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STAT_DONE) |-> (!rec_used && rec_digits == '0
      && older_slot == '0 && newer_slot == '0))
    else $error("record fields on a failed item");
`endif

endmodule
`default_nettype wire
